[design/sem_pkg.sv]
package sem_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_W     = 14;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned GRAD_W    = 11;
  localparam int unsigned ABS_W     = 10;
  localparam int unsigned MIN_SIZE  = 3;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 14'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 14'd480;
  localparam logic [PIX_W-1:0] MAG_MAX      = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  // One line store entry: two rows above the current one, then one row above.
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } line_pair_t;

endpackage

[design/sem_line_store.sv]
module sem_line_store #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output sem_pkg::line_pair_t rd_data_o,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  sem_pkg::line_pair_t wr_data_i
);

  sem_pkg::line_pair_t mem [DEPTH];
  sem_pkg::line_pair_t rd_q;
  sem_pkg::line_pair_t fwd_data_q;
  logic                fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // read and write of the same entry on one edge: take the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

[design/sobel_edge_magnitude.sv]
// Streaming 3x3 Sobel edge detector, |Gx|+|Gy| saturated at 255. Takes one pixel
// per clock in raster order when not stalled, and sustains that rate indefinitely;
// the single line store (one read and one write per cycle) sets it. A result is
// registered out after its center's lower right neighbor is taken, only for
// interior pixels, with row_last/frame_last marks. frame_start restarts the
// position; without it the position wraps after the last pixel of a frame. Sizes
// are clamped to 3..MAX_WIDTH/MAX_HEIGHT and may be rewritten only while idle;
// raising the width mid-frame reads stale line data. No clearing pass after reset.
module sobel_edge_magnitude #(
  parameter int unsigned MAX_WIDTH  = 8192,
  parameter int unsigned MAX_HEIGHT = 8192
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sem_pkg::PIX_W-1:0]     pixel_value_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sem_pkg::PIX_W-1:0]     edge_magnitude_o,
  output logic                          row_last_o,
  output logic                          frame_last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned PW = sem_pkg::PIX_W;

  // configuration
  logic [sem_pkg::CFG_W-1:0] width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sem_pkg::WIDTH_RESET;
      height_q <= sem_pkg::HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (sem_pkg::reg_idx_e'(cfg_index_i))
        sem_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        sem_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [CW:0] w_use;
  logic [RW:0] h_use;

  always_comb begin
    if (32'(width_q) < 32'(sem_pkg::MIN_SIZE)) begin
      w_use = (CW+1)'(sem_pkg::MIN_SIZE);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_use = (CW+1)'(MAX_WIDTH);
    end else begin
      w_use = (CW+1)'(width_q);
    end
    if (32'(height_q) < 32'(sem_pkg::MIN_SIZE)) begin
      h_use = (RW+1)'(sem_pkg::MIN_SIZE);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_use = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_use = (RW+1)'(height_q);
    end
  end

  // pipeline handshake
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic out_free, s3_rdy, s2_rdy, s1_rdy, s1_adv, in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s3_rdy     = !s3_valid_q || out_free;
  assign s2_rdy     = !s2_valid_q || s3_rdy;
  assign s1_rdy     = !s1_valid_q || s2_rdy;
  assign s1_adv     = s1_valid_q && s2_rdy;
  assign in_ready_o = s1_rdy;
  assign in_fire    = in_valid_i && s1_rdy;

  // position
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [CW:0]   c0, c1, cn;
  logic [RW:0]   r0, r1, r2, rn;
  logic          emit, rl, fl;

  always_comb begin
    c0 = frame_start_i ? '0 : {1'b0, col_q};
    r0 = frame_start_i ? '0 : {1'b0, row_q};
    if (c0 >= w_use) begin
      c1 = '0;
      r1 = r0 + (RW+1)'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2   = (r1 >= h_use) ? '0 : r1;
    emit = (r2 >= (RW+1)'(2)) && (c1 >= (CW+1)'(2));
    rl   = (c1 == w_use - (CW+1)'(1));
    fl   = rl && (r2 == h_use - (RW+1)'(1));
    cn   = c1 + (CW+1)'(1);
    rn   = r2;
    if (cn >= w_use) begin
      cn = '0;
      rn = r2 + (RW+1)'(1);
      if (rn >= h_use) begin
        rn = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= cn[CW-1:0];
      row_q <= rn[RW-1:0];
    end
  end

  // stage 1: line store read data
  logic [PW-1:0]       s1_pix_q;
  logic [CW-1:0]       s1_addr_q;
  logic                s1_emit_q, s1_rl_q, s1_fl_q;
  sem_pkg::line_pair_t rd_pair, wr_pair;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q  <= pixel_value_i;
      s1_addr_q <= c1[CW-1:0];
      s1_emit_q <= emit;
      s1_rl_q   <= rl;
      s1_fl_q   <= fl;
    end
  end

  assign wr_pair.upper  = rd_pair.middle;
  assign wr_pair.middle = s1_pix_q;

  sem_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (c1[CW-1:0]),
    .rd_data_o (rd_pair),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_pair)
  );

  // 3x3 window, row-major, shifts once per pixel
  logic [PW-1:0] win_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= rd_pair.upper;
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[5] <= rd_pair.middle;
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[8] <= s1_pix_q;
    end
  end

  // stage 2: gradients from the window
  logic s2_rl_q, s2_fl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_valid_q <= s1_adv && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_rl_q <= s1_rl_q;
      s2_fl_q <= s1_fl_q;
    end
  end

  logic [sem_pkg::ABS_W-1:0]         gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [sem_pkg::GRAD_W-1:0] gx, gy;

  always_comb begin
    gx_pos = {2'b0, win_q[0]} + {1'b0, win_q[1], 1'b0} + {2'b0, win_q[2]};
    gx_neg = {2'b0, win_q[6]} + {1'b0, win_q[7], 1'b0} + {2'b0, win_q[8]};
    gy_pos = {2'b0, win_q[0]} + {1'b0, win_q[3], 1'b0} + {2'b0, win_q[6]};
    gy_neg = {2'b0, win_q[2]} + {1'b0, win_q[5], 1'b0} + {2'b0, win_q[8]};
    gx     = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    gy     = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
  end

  // stage 3: magnitude
  logic signed [sem_pkg::GRAD_W-1:0] gx_q, gy_q;
  logic                              s3_rl_q, s3_fl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s3_rdy) begin
      gx_q    <= gx;
      gy_q    <= gy;
      s3_rl_q <= s2_rl_q;
      s3_fl_q <= s2_fl_q;
    end
  end

  logic [sem_pkg::ABS_W-1:0]  ax, ay;
  logic [sem_pkg::ABS_W:0]    mag_sum;
  logic [PW-1:0]              mag;

  always_comb begin
    ax      = gx_q[sem_pkg::GRAD_W-1] ? sem_pkg::ABS_W'(-gx_q) : sem_pkg::ABS_W'(gx_q);
    ay      = gy_q[sem_pkg::GRAD_W-1] ? sem_pkg::ABS_W'(-gy_q) : sem_pkg::ABS_W'(gy_q);
    mag_sum = {1'b0, ax} + {1'b0, ay};
    mag     = (mag_sum > (sem_pkg::ABS_W+1)'(sem_pkg::MAG_MAX)) ?
              sem_pkg::MAG_MAX : mag_sum[PW-1:0];
  end

  // output register
  logic [PW-1:0] mag_q;
  logic          rl_q, fl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q && out_free) begin
      mag_q <= mag;
      rl_q  <= s3_rl_q;
      fl_q  <= s3_fl_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign edge_magnitude_o = mag_q;
  assign row_last_o       = rl_q;
  assign frame_last_o     = fl_q;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import sem_pkg::*;

  localparam int unsigned MAX_W = 8192;
  localparam int unsigned MAX_H = 8192;
  localparam int unsigned COL_AW = $clog2(MAX_W);
  localparam int unsigned IDLE_PCT = 18;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RAND_ITEMS = 800;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             start;
    logic             hold;
  } pixel_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] magnitude;
    logic             row_last;
    logic             frame_last;
  } edge_res_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                 in_valid = 1'b0;
  logic [PIX_W-1:0]     pixel_value = '0;
  logic                 frame_start = 1'b0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [PIX_W-1:0]     edge_magnitude_o;
  logic                 row_last_o;
  logic                 frame_last_o;
  logic                 cfg_ready_o;

  sobel_edge_magnitude #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .pixel_value_i    (pixel_value),
    .frame_start_i    (frame_start),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .edge_magnitude_o (edge_magnitude_o),
    .row_last_o       (row_last_o),
    .frame_last_o     (frame_last_o),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  pixel_item_t pending_pixels[$];
  edge_res_t   expected_edges[$];
  pixel_item_t next_pixel;
  edge_res_t   want;
  int          fail_cnt = 0;
  logic        no_gaps = 1'b0;

  // predictor state
  logic [CFG_W-1:0] width_reg = WIDTH_RESET;
  logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
  logic [PIX_W-1:0] upper_line [MAX_W] = '{default: '0};
  logic [PIX_W-1:0] middle_line [MAX_W] = '{default: '0};
  logic [PIX_W-1:0] win [9] = '{default: '0};
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;

  // stimulus generator state
  int unsigned gen_pos = 0;
  int unsigned gen_mode = 0;
  int unsigned gen_base = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned hi);
    if (32'(v) < MIN_SIZE) return MIN_SIZE;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  task automatic predict_edge(logic [PIX_W-1:0] pix, logic start);
    int unsigned      w, h;
    logic [PIX_W-1:0] up, mid;
    logic [COL_AW-1:0] ci;
    int               gx, gy, mag;
    edge_res_t        res;
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, MAX_H);
    if (start) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    ci  = COL_AW'(col_pos);
    up  = upper_line[ci];
    mid = middle_line[ci];
    upper_line[ci]  = mid;
    middle_line[ci] = pix;
    win[0] = win[1]; win[1] = win[2]; win[2] = up;
    win[3] = win[4]; win[4] = win[5]; win[5] = mid;
    win[6] = win[7]; win[7] = win[8]; win[8] = pix;
    if (row_pos >= 2 && col_pos >= 2) begin
      gx = (int'(win[0]) - int'(win[6])) + 2 * (int'(win[1]) - int'(win[7]))
         + (int'(win[2]) - int'(win[8]));
      gy = (int'(win[0]) - int'(win[2])) + 2 * (int'(win[3]) - int'(win[5]))
         + (int'(win[6]) - int'(win[8]));
      mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      res.magnitude  = (mag > 255) ? MAG_MAX : PIX_W'(mag);
      res.row_last   = (col_pos == w - 1);
      res.frame_last = res.row_last && (row_pos == h - 1);
      expected_edges.push_back(res);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // pixel driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      pixel_value <= '0;
      frame_start <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) predict_edge(pixel_value, frame_start);
      if (!in_valid || in_ready_o) begin
        if (pending_pixels.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT) &&
            !(pending_pixels[0].hold && expected_edges.size() != 0)) begin
          next_pixel = pending_pixels.pop_front();
          in_valid    <= 1'b1;
          pixel_value <= next_pixel.pix;
          frame_start <= next_pixel.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_edges.size() == 0) begin
          $error("result transfer with nothing pending: edge_magnitude %0d", edge_magnitude_o);
          fail_cnt++;
        end else begin
          want = expected_edges.pop_front();
          if (edge_magnitude_o !== want.magnitude) begin
            $error("edge_magnitude: expected %0d, got %0d", want.magnitude, edge_magnitude_o);
            fail_cnt++;
          end
          if (row_last_o !== want.row_last) begin
            $error("row_last: expected %0d, got %0d", want.row_last, row_last_o);
            fail_cnt++;
          end
          if (frame_last_o !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, frame_last_o);
            fail_cnt++;
          end
        end
      end
      out_ready <= no_gaps || $urandom_range(99) >= IDLE_PCT;
    end
  end

  function automatic logic [PIX_W-1:0] gen_pixel();
    int v;
    case (gen_mode)
      0: return PIX_W'($urandom_range(255));
      1: begin
        v = int'(gen_base) + int'($urandom_range(12)) - 6;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PIX_W'(v);
      end
      default: return $urandom_range(1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  task automatic add_pixel(logic [PIX_W-1:0] pix, logic start, logic hold);
    pixel_item_t it;
    it.pix   = pix;
    it.start = start;
    it.hold  = hold;
    pending_pixels.push_back(it);
  endtask

  // mostly whole frames with random content; noise_pct adds restarts mid-frame
  task automatic push_stream(int unsigned n, int unsigned w, int unsigned h, bit force_start,
                             int unsigned noise_pct, logic quiet);
    logic start;
    @(negedge clk_i);
    no_gaps = quiet;
    if (force_start) gen_pos = 0;
    for (int unsigned i = 0; i < n; i++) begin
      start = 1'b0;
      if (i == 0 && force_start) start = 1'b1;
      else if (gen_pos == 0) start = ($urandom_range(99) < 85);
      else if ($urandom_range(99) < noise_pct) start = 1'b1;
      if (start) gen_pos = 0;
      if (gen_pos == 0) begin
        gen_mode = $urandom_range(2);
        gen_base = $urandom_range(255);
      end
      add_pixel(gen_pixel(), start, i == n / 2);
      gen_pos = (gen_pos + 1) % (w * h);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_pixels.size() != 0 || in_valid || expected_edges.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  initial begin
    logic [CFG_W-1:0] w_val, h_val;
    int unsigned      cur_w, new_w, new_h, pick, n, sent, ph;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset sizes: part of the first row only, nothing may come out
    push_stream(160, 640, 480, 0, 0, 1'b0);
    wait_idle();

    // sizes below range clamp to 3x3
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(2));
    @(negedge clk_i);
    for (int i = 0; i < 9; i++) add_pixel((i < 3) ? 8'hFF : 8'h00, i == 0, 1'b0);
    // next frame wraps in without frame_start
    for (int i = 0; i < 9; i++) add_pixel((i % 3 == 2) ? 8'd40 : 8'd0, 1'b0, 1'b0);
    for (int i = 0; i < 2; i++) add_pixel(PIX_W'($urandom_range(255)), 1'b0, 1'b0);
    wait_idle();
    // wider: restart mid-frame
    write_reg(REG_IMAGE_WIDTH, CFG_W'(5));
    push_stream(9, 5, 3, 1, 0, 1'b0);
    wait_idle();
    // narrower with column already past the new width
    write_reg(REG_IMAGE_WIDTH, CFG_W'(3));
    push_stream(3, 3, 3, 0, 0, 1'b0);
    cur_w = 3;

    sent = 0;
    ph = 0;
    while (sent < RAND_ITEMS) begin
      wait_idle();
      w_val = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(2)) : CFG_W'($urandom_range(3, 12));
      h_val = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(2)) : CFG_W'($urandom_range(3, 7));
      pick = $urandom_range(3);
      if (pick != 0) write_reg(REG_IMAGE_WIDTH, w_val);
      if (pick != 1) write_reg(REG_IMAGE_HEIGHT, h_val);
      new_w = eff_size(width_reg, MAX_W);
      new_h = eff_size(height_reg, MAX_H);
      n = (ph == 3) ? 250 : $urandom_range(40, 160);
      // a wider row would read line entries never written: restart the frame
      push_stream(n, new_w, new_h, new_w > cur_w || $urandom_range(1) == 1, 3, ph == 3);
      cur_w = new_w;
      sent += n;
      ph++;
    end

    // height above range clamps to the maximum
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, CFG_W'(3));
    write_reg(REG_IMAGE_HEIGHT, '1);
    push_stream(30, 3, MAX_H, 1, 0, 1'b0);

    wait_idle();
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
